// ===== hdl/fke_pkg.sv =====
package fke_pkg;

    // link types
    localparam logic [1:0] LINK_ETH    = 2'd0;
    localparam logic [1:0] LINK_COOKED = 2'd1;

    // register indexes
    localparam logic REG_LINK_TYPE = 1'b0;
    localparam logic REG_RAW_OFS   = 1'b1;

    localparam logic [15:0] TYPE_VLAN    = 16'h8100;
    localparam logic [15:0] TYPE_IPV4    = 16'h0800;
    localparam logic [15:0] TYPE_MAX_LEN = 16'd1500;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;

    localparam int QueueDepth = 4;

    typedef enum logic [1:0] {
        STAGE_LINK,
        STAGE_TAG,
        STAGE_IP
    } t_stage;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] wire_length;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port_class;
        logic [15:0] dest_port_class;
        logic [15:0] payload_length;
    } t_out_beat;

    // raw key as the parser leaves it, ports not yet bucketed
    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] len;
    } t_key;

    function automatic logic [15:0] port_class(input logic [15:0] p);
        logic [15:0] c;
        if (p <= 16'd1024)       c = p;
        else if (p <= 16'd9999)  c = 16'd1025;
        else if (p <= 16'd19999) c = 16'd10000;
        else if (p <= 16'd29999) c = 16'd20000;
        else if (p <= 16'd39999) c = 16'd30000;
        else if (p <= 16'd49999) c = 16'd40000;
        else if (p <= 16'd59999) c = 16'd50000;
        else                     c = 16'd60000;
        return c;
    endfunction

endpackage

// ===== hdl/fke_front.sv =====
module fke_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  fke_pkg::t_in_beat i_beat,
    input  logic [1:0]        i_link_type,
    input  logic [7:0]        i_raw_ofs,
    output logic              o_push,
    output fke_pkg::t_key     o_key
);

    fke_pkg::t_stage r_stage, n_stage;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_etype, n_etype;
    logic [15:0] r_hdr_start, n_hdr_start;
    logic [3:0]  r_hwords, n_hwords;
    logic        r_frag, n_frag;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;
    logic [31:0] r_ports, n_ports;
    logic        r_drop, n_drop;
    logic        r_done, n_done;

    logic        emit;
    logic        take;
    logic [15:0] tval;
    logic [15:0] rel_link;
    logic [15:0] rel;
    logic [15:0] po;
    logic [15:0] pend;
    logic [15:0] done_at;
    logic        needed;
    logic [7:0]  b;
    logic [15:0] wire_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= fke_pkg::STAGE_LINK;
            r_pos       <= '0;
            r_etype     <= '0;
            r_hdr_start <= '0;
            r_hwords    <= '0;
            r_frag      <= 1'b0;
            r_proto     <= '0;
            r_src       <= '0;
            r_dst       <= '0;
            r_ports     <= '0;
            r_drop      <= 1'b0;
            r_done      <= 1'b0;
        end else if (i_accept) begin
            r_stage     <= n_stage;
            r_pos       <= n_pos;
            r_etype     <= n_etype;
            r_hdr_start <= n_hdr_start;
            r_hwords    <= n_hwords;
            r_frag      <= n_frag;
            r_proto     <= n_proto;
            r_src       <= n_src;
            r_dst       <= n_dst;
            r_ports     <= n_ports;
            r_drop      <= n_drop;
            r_done      <= n_done;
        end
    end

    // parse one beat
    always_comb begin
        b           = i_beat.data_byte;
        wire_len    = i_beat.wire_length;
        n_stage     = r_stage;
        n_etype     = r_etype;
        n_hdr_start = r_hdr_start;
        n_hwords    = r_hwords;
        n_frag      = r_frag;
        n_proto     = r_proto;
        n_src       = r_src;
        n_dst       = r_dst;
        n_ports     = r_ports;
        n_drop      = r_drop;
        n_done      = r_done;
        n_pos       = r_pos;
        emit        = 1'b0;
        take        = 1'b0;
        tval        = r_etype;
        rel_link    = r_pos - r_hdr_start;
        rel         = '0;
        po          = '0;
        pend        = '0;
        done_at     = '0;
        needed      = 1'b0;
        o_key       = '0;

        if (!r_drop && !r_done) begin
            // link header and tags
            unique case (r_stage)
                fke_pkg::STAGE_LINK: begin
                    if (i_link_type == fke_pkg::LINK_ETH) begin
                        if (r_pos == 16'd12) n_etype = {b, 8'h00};
                        else if (r_pos == 16'd13) begin
                            tval = {r_etype[15:8], b};
                            take = 1'b1;
                        end
                    end else if (i_link_type == fke_pkg::LINK_COOKED) begin
                        if (wire_len < 16'd16) n_drop = 1'b1;
                        else if (r_pos == 16'd14) n_etype = {b, 8'h00};
                        else if (r_pos == 16'd15) begin
                            tval = {r_etype[15:8], b};
                            if (tval <= fke_pkg::TYPE_MAX_LEN) n_drop = 1'b1;
                            else take = 1'b1;
                        end
                    end else begin
                        n_stage     = fke_pkg::STAGE_IP;
                        n_hdr_start = {8'h00, i_raw_ofs};
                    end
                end
                fke_pkg::STAGE_TAG: begin
                    if (rel_link == 16'd2) n_etype = {b, 8'h00};
                    else if (rel_link == 16'd3) begin
                        tval = {r_etype[15:8], b};
                        if (tval <= fke_pkg::TYPE_MAX_LEN) n_drop = 1'b1;
                        else take = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // decide on a finished type field
            if (take) begin
                n_etype     = tval;
                n_hdr_start = r_pos + 16'd1;
                if (tval == fke_pkg::TYPE_VLAN) n_stage = fke_pkg::STAGE_TAG;
                else if (tval == fke_pkg::TYPE_IPV4) n_stage = fke_pkg::STAGE_IP;
                else n_drop = 1'b1;
            end

            // IPv4 header fields
            if (!n_drop && n_stage == fke_pkg::STAGE_IP && r_pos >= n_hdr_start) begin
                rel = r_pos - n_hdr_start;
                if (rel == 16'd0) n_hwords = b[3:0];
                else if (rel == 16'd6) n_frag = (b[5:0] != 6'd0);
                else if (rel == 16'd7) n_frag = r_frag | (b != 8'd0);
                else if (rel == 16'd9) n_proto = b;
                else if (rel >= 16'd12 && rel <= 16'd15) n_src = {r_src[23:0], b};
                else if (rel >= 16'd16 && rel <= 16'd19) n_dst = {r_dst[23:0], b};
                po = {10'd0, n_hwords, 2'b00};
                if (rel >= po && rel < po + 16'd4) n_ports = {r_ports[23:0], b};
                needed = !n_frag &&
                         (n_proto == fke_pkg::PROTO_TCP || n_proto == fke_pkg::PROTO_UDP);
                pend    = po + 16'd3;
                done_at = (needed && pend > 16'd19) ? pend : 16'd19;
                if (rel >= 16'd19 && rel == done_at) begin
                    emit           = 1'b1;
                    n_done         = 1'b1;
                    o_key.protocol = n_proto;
                    o_key.src      = n_src;
                    o_key.dst      = n_dst;
                    o_key.sport    = needed ? n_ports[31:16] : 16'd0;
                    o_key.dport    = needed ? n_ports[15:0] : 16'd0;
                    if (i_link_type == fke_pkg::LINK_ETH)
                        o_key.len = (wire_len >= 16'd14) ? wire_len - 16'd14 : 16'd0;
                    else if (i_link_type == fke_pkg::LINK_COOKED)
                        o_key.len = (wire_len >= 16'd16) ? wire_len - 16'd16 : 16'd0;
                    else
                        o_key.len = wire_len;
                end
            end

            // overlong frame
            if (!n_drop && !n_done && r_pos == fke_pkg::POS_MAX) n_drop = 1'b1;
        end

        // frame boundary
        if (i_beat.last_byte) begin
            n_stage     = fke_pkg::STAGE_LINK;
            n_pos       = '0;
            n_etype     = '0;
            n_hdr_start = '0;
            n_hwords    = '0;
            n_frag      = 1'b0;
            n_proto     = '0;
            n_src       = '0;
            n_dst       = '0;
            n_ports     = '0;
            n_drop      = 1'b0;
            n_done      = 1'b0;
        end else if (r_pos != fke_pkg::POS_MAX) begin
            n_pos = r_pos + 16'd1;
        end
    end

    assign o_push = i_accept && emit;

endmodule

// ===== hdl/fke_queue.sv =====
module fke_queue #(
    parameter int Depth = fke_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fke_pkg::t_key i_key,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output fke_pkg::t_key o_key
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] Full    = CntW'(Depth);

    fke_pkg::t_key   r_mem [Depth];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // pointer and fill update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) n_wr = (r_wr == LastIdx) ? '0 : r_wr + 1'b1;
        if (i_pop)  n_rd = (r_rd == LastIdx) ? '0 : r_rd + 1'b1;
        if (i_push && !i_pop) n_count = r_count + 1'b1;
        else if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == Full);
    assign o_key   = r_mem[r_rd];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Full)
        else $error("queue fill out of range");

endmodule

// ===== hdl/fke_back.sv =====
module fke_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  fke_pkg::t_key      i_key,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output fke_pkg::t_out_beat o_beat
);

    logic               r_valid, n_valid;
    fke_pkg::t_out_beat r_beat, n_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= n_valid;
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
    end

    // refill output register when empty or being taken
    always_comb begin
        o_pop   = i_q_valid && (!r_valid || !i_stall);
        n_valid = r_valid;
        n_beat  = r_beat;
        if (r_valid && !i_stall) n_valid = 1'b0;
        if (o_pop) begin
            n_valid                  = 1'b1;
            n_beat.ip_protocol       = i_key.protocol;
            n_beat.source_address    = i_key.src;
            n_beat.dest_address      = i_key.dst;
            n_beat.source_port_class = fke_pkg::port_class(i_key.sport);
            n_beat.dest_port_class   = fke_pkg::port_class(i_key.dport);
            n_beat.payload_length    = i_key.len;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== hdl/ipv4_flow_key_extractor.sv =====
// IPv4 flow key extractor. Takes one frame byte per beat at a rate of one byte per
// cycle while the key queue is not full and emits one flow key per IPv4 frame:
// protocol, addresses, bucketed ports and payload length. The parser sees each byte
// once as it is accepted; a key goes into a small queue (QUEUE_DEPTH entries) and
// then through a port-bucketing output register. Input stall rises only when that
// queue is full. link_type (addr 0) and raw_ip_offset (addr 4) are written over the
// APB port, by the user only while the block is idle; the block does not enforce it.
module ipv4_flow_key_extractor #(
    parameter int QUEUE_DEPTH = fke_pkg::QueueDepth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fke_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fke_pkg::t_out_beat o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [1:0]    r_link_type;
    logic [7:0]    r_raw_ofs;
    logic          accept;
    logic          push;
    logic          pop;
    logic          q_valid;
    logic          q_full;
    fke_pkg::t_key f_key;
    fke_pkg::t_key q_key;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_type <= '0;
            r_raw_ofs   <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                fke_pkg::REG_LINK_TYPE: r_link_type <= pwdata[1:0];
                fke_pkg::REG_RAW_OFS:   r_raw_ofs   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            fke_pkg::REG_LINK_TYPE: prdata = {30'd0, r_link_type};
            fke_pkg::REG_RAW_OFS:   prdata = {24'd0, r_raw_ofs};
            default:                prdata = '0;
        endcase
    end

    assign pready     = 1'b1;
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    fke_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_beat      (i_in),
        .i_link_type (r_link_type),
        .i_raw_ofs   (r_raw_ofs),
        .o_push      (push),
        .o_key       (f_key)
    );

    fke_queue #(
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_key   (f_key),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_key   (q_key)
    );

    fke_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_key     (q_key),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_beat    (o_out)
    );

endmodule
